// ===== design/cpra_pkg.sv =====
// Shared constants and field widths of the contiguous page run allocator.
package cpra_pkg;

  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 11;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 10;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESIZE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

endpackage

// ===== design/cpra_in_if.sv =====
// Request channel of the allocator: valid, ready and one request item.
interface cpra_in_if import cpra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [COUNT_W-1:0]  page_count;
  logic [INDEX_W-1:0]  page_index;

  modport source (output valid, kind, page_count, page_index, input ready);
  modport sink   (input valid, kind, page_count, page_index, output ready);
endinterface

// ===== design/cpra_out_if.sv =====
// Result channel of the allocator: valid, ready and one result item.
interface cpra_out_if import cpra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   start_slot;

  modport source (output valid, status, start_slot, input ready);
  modport sink   (input valid, status, start_slot, output ready);
endinterface

// ===== design/cpra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cpra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/contiguous_page_run_allocator_top.sv =====
// Contiguous page run allocator: slot table in RAM, walked by a sequencer.
//
// Requests arrive on in_req (kind, page_count, page_index) and each gives
// exactly one result on out_rsp (status, start_slot); both are valid/ready.
// After reset a clearing pass writes every slot of the table, with
// in_req.ready low. Then one request is worked at a time.
// Every table probe is a RAM read in an address state, then a check state,
// so each kind of request is worked in these steps:
//   single-page allocate: one probe per taken slot passed, then the free slot is marked;
//   multi-page allocate: a bit-serial remainder step for the start hint,
//     then probes from that start (a taken run is skipped in one probe
//     when its head is hit), and one write per page placed;
//   free: a head probe, then one write per page cleared;
//   resize: a head probe, then probes of the added pages and one write per page written.
// Requests are taken again as soon as a result sits in the output register;
// if the receiver stalls, a second finished result waits in the sequencer
// until the output register is free.
module contiguous_page_run_allocator_top import cpra_pkg::*; #(
  parameter int SLOT_COUNT = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  cpra_in_if.sink    in_req,
  cpra_out_if.source out_rsp
);
  localparam int IW  = $clog2(SLOT_COUNT);
  localparam int CW  = $clog2(SLOT_COUNT + 1);
  localparam int NW  = ((CW > COUNT_W) ? CW : COUNT_W) + 1;
  localparam int CNW = $clog2(NW);
  localparam int EW  = IW + 1;
  localparam logic [NW-1:0] SC_N = NW'(SLOT_COUNT);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DIV    = 5'd2;
  localparam logic [4:0] S_S1RD   = 5'd3;
  localparam logic [4:0] S_S1CHK  = 5'd4;
  localparam logic [4:0] S_MRD    = 5'd5;
  localparam logic [4:0] S_MCHK   = 5'd6;
  localparam logic [4:0] S_HRD    = 5'd7;
  localparam logic [4:0] S_HCHK   = 5'd8;
  localparam logic [4:0] S_PLACE  = 5'd9;
  localparam logic [4:0] S_HDRD   = 5'd10;
  localparam logic [4:0] S_HDCHK  = 5'd11;
  localparam logic [4:0] S_FREE   = 5'd12;
  localparam logic [4:0] S_SHRINK = 5'd13;
  localparam logic [4:0] S_GRD    = 5'd14;
  localparam logic [4:0] S_GCHK   = 5'd15;
  localparam logic [4:0] S_GWR    = 5'd16;
  localparam logic [4:0] S_GHD    = 5'd17;
  localparam logic [4:0] S_DONE   = 5'd18;

  logic [4:0]          state_r, state_nxt;
  logic [IW-1:0]       addr_r, addr_nxt;
  logic [IW-1:0]       head_r, head_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic [NW-1:0]       lim_r, lim_nxt;
  logic [NW-1:0]       s_r, s_nxt;
  logic [NW-1:0]       d_r, d_nxt;
  logic [NW-1:0]       k_r, k_nxt;
  logic [NW-1:0]       old_r, old_nxt;
  logic                taken_h_r, taken_h_nxt;
  logic [NW-1:0]       hint_r, hint_nxt;
  logic [NW-1:0]       rem_r, rem_nxt;
  logic [NW-1:0]       hint_sh_r, hint_sh_nxt;
  logic [CNW-1:0]      cnt_r, cnt_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;

  logic          we;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;
  logic          rd_taken;
  logic [IW-1:0] rd_extra;

  logic [NW-1:0] n_in;
  logic [NW-1:0] idx_in;
  logic [NW-1:0] addr_n;
  logic [NW-1:0] head_n;
  logic [NW-1:0] run_end;
  logic [NW-1:0] d_m;
  logic [NW-1:0] d_h;
  logic [NW:0]   rem_sh;
  logic [NW:0]   rem_sub;
  logic [NW-1:0] rem_new;

  // Start index of the scan at distance d from s, modulo the search limit.
  function automatic logic [IW-1:0] wrap_idx(input logic [NW-1:0] s,
                                             input logic [NW-1:0] d,
                                             input logic [NW-1:0] lim);
    logic [NW-1:0] t;
    t = s + d;
    if (t >= lim) begin
      t = t - lim;
    end
    return IW'(t);
  endfunction

  cpra_ram #(.WIDTH(EW), .DEPTH(SLOT_COUNT)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (addr_r),
    .wdata (wdata),
    .raddr (addr_r),
    .rdata (rdata)
  );

  assign rd_taken = rdata[EW-1];
  assign rd_extra = rdata[IW-1:0];

  assign n_in    = (in_req.page_count == '0) ? NW'(1) : NW'(in_req.page_count);
  assign idx_in  = NW'(in_req.page_index);
  assign addr_n  = NW'(addr_r);
  assign head_n  = NW'(head_r);
  assign run_end = head_n + n_r - NW'(1);
  assign d_m     = d_r + NW'(rd_extra) + NW'(1);
  assign d_h     = d_r + addr_n - head_n + NW'(1);
  assign rem_sh  = {rem_r, hint_sh_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, lim_r};
  assign rem_new = (rem_sh >= {1'b0, lim_r}) ? NW'(rem_sub) : NW'(rem_sh);

  assign in_req.ready      = (state_r == S_IDLE);
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.start_slot = out_slot_r;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    head_nxt       = head_r;
    kind_nxt       = kind_r;
    n_nxt          = n_r;
    lim_nxt        = lim_r;
    s_nxt          = s_r;
    d_nxt          = d_r;
    k_nxt          = k_r;
    old_nxt        = old_r;
    taken_h_nxt    = taken_h_r;
    hint_nxt       = hint_r;
    rem_nxt        = rem_r;
    hint_sh_nxt    = hint_sh_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    slot_nxt       = slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    we             = 1'b0;
    wdata          = '0;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        we = 1'b1;
        addr_nxt = addr_r + IW'(1);
        if (addr_r == LAST_SLOT) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_req.valid) begin
          kind_nxt   = in_req.kind;
          n_nxt      = n_in;
          status_nxt = ST_OK;
          slot_nxt   = '0;
          if (in_req.kind == KIND_ALLOC) begin
            if (n_in >= SC_N) begin
              status_nxt = ST_NOSPACE;
              state_nxt  = S_DONE;
            end else if (n_in == NW'(1)) begin
              addr_nxt  = (hint_r >= SC_N) ? IW'(hint_r - SC_N) : IW'(hint_r);
              d_nxt     = '0;
              state_nxt = S_S1RD;
            end else begin
              lim_nxt     = SC_N - n_in;
              rem_nxt     = '0;
              hint_sh_nxt = hint_r;
              cnt_nxt     = '0;
              state_nxt   = S_DIV;
            end
          end else if (in_req.kind == KIND_FREE || in_req.kind == KIND_RESIZE) begin
            if (idx_in >= SC_N) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              addr_nxt  = IW'(idx_in);
              head_nxt  = IW'(idx_in);
              state_nxt = S_HDRD;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DIV: begin
        // One remainder bit a cycle: hint modulo the search limit.
        rem_nxt     = rem_new;
        hint_sh_nxt = hint_sh_r << 1;
        cnt_nxt     = cnt_r + CNW'(1);
        if (cnt_r == CNW'(NW - 1)) begin
          s_nxt     = rem_new;
          d_nxt     = '0;
          addr_nxt  = IW'(rem_new);
          state_nxt = S_MRD;
        end
      end
      S_S1RD: state_nxt = S_S1CHK;
      S_S1CHK: begin
        if (!rd_taken) begin
          we         = 1'b1;
          wdata      = {1'b1, {IW{1'b0}}};
          slot_nxt   = SLOT_W'(addr_r);
          state_nxt  = S_DONE;
        end else if (d_r + NW'(1) == SC_N) begin
          status_nxt = ST_NOSPACE;
          state_nxt  = S_DONE;
        end else begin
          d_nxt     = d_r + NW'(1);
          addr_nxt  = (addr_r == LAST_SLOT) ? '0 : addr_r + IW'(1);
          state_nxt = S_S1RD;
        end
      end
      S_MRD: state_nxt = S_MCHK;
      S_MCHK: begin
        if (rd_taken) begin
          // Skip the taken run in one step when this slot is its head.
          if (d_m >= lim_r) begin
            status_nxt = ST_NOSPACE;
            state_nxt  = S_DONE;
          end else begin
            d_nxt     = d_m;
            addr_nxt  = wrap_idx(s_r, d_m, lim_r);
            state_nxt = S_MRD;
          end
        end else begin
          head_nxt  = addr_r;
          addr_nxt  = addr_r + IW'(1);
          state_nxt = S_HRD;
        end
      end
      S_HRD: state_nxt = S_HCHK;
      S_HCHK: begin
        if (rd_taken) begin
          if (d_h >= lim_r) begin
            status_nxt = ST_NOSPACE;
            state_nxt  = S_DONE;
          end else begin
            d_nxt     = d_h;
            addr_nxt  = wrap_idx(s_r, d_h, lim_r);
            state_nxt = S_MRD;
          end
        end else if (addr_n == run_end) begin
          addr_nxt  = head_r;
          hint_nxt  = head_n + n_r;
          state_nxt = S_PLACE;
        end else begin
          addr_nxt  = addr_r + IW'(1);
          state_nxt = S_HRD;
        end
      end
      S_PLACE: begin
        we    = 1'b1;
        wdata = (addr_r == head_r) ? {1'b1, IW'(n_r - NW'(1))} : {1'b1, {IW{1'b0}}};
        if (addr_n == run_end) begin
          slot_nxt  = SLOT_W'(head_r);
          state_nxt = S_DONE;
        end else begin
          addr_nxt = addr_r + IW'(1);
        end
      end
      S_HDRD: state_nxt = S_HDCHK;
      S_HDCHK: begin
        taken_h_nxt = rd_taken;
        old_nxt     = NW'(rd_extra) + NW'(1);
        if (kind_r == KIND_FREE) begin
          k_nxt     = '0;
          state_nxt = S_FREE;
        end else if (n_r <= NW'(rd_extra) + NW'(1)) begin
          we       = 1'b1;
          wdata    = {rd_taken, IW'(n_r - NW'(1))};
          slot_nxt = SLOT_W'(head_r);
          if (n_r < NW'(rd_extra) + NW'(1) && head_n + n_r < SC_N) begin
            k_nxt     = n_r;
            addr_nxt  = IW'(head_n + n_r);
            state_nxt = S_SHRINK;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (head_n + n_r > SC_N) begin
          status_nxt = ST_NOSPACE;
          state_nxt  = S_DONE;
        end else begin
          k_nxt     = NW'(rd_extra) + NW'(1);
          addr_nxt  = IW'(head_n + NW'(rd_extra) + NW'(1));
          state_nxt = S_GRD;
        end
      end
      S_FREE: begin
        we = 1'b1;
        if (k_r + NW'(1) == old_r || addr_n + NW'(1) >= SC_N) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt    = k_r + NW'(1);
          addr_nxt = addr_r + IW'(1);
        end
      end
      S_SHRINK: begin
        we = 1'b1;
        if (k_r + NW'(1) == old_r || addr_n + NW'(1) >= SC_N) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt    = k_r + NW'(1);
          addr_nxt = addr_r + IW'(1);
        end
      end
      S_GRD: state_nxt = S_GCHK;
      S_GCHK: begin
        if (rd_taken) begin
          status_nxt = ST_NOSPACE;
          state_nxt  = S_DONE;
        end else if (k_r == n_r - NW'(1)) begin
          k_nxt     = old_r;
          addr_nxt  = IW'(head_n + old_r);
          state_nxt = S_GWR;
        end else begin
          k_nxt     = k_r + NW'(1);
          addr_nxt  = addr_r + IW'(1);
          state_nxt = S_GRD;
        end
      end
      S_GWR: begin
        we    = 1'b1;
        wdata = {1'b1, {IW{1'b0}}};
        if (k_r == n_r - NW'(1)) begin
          addr_nxt  = head_r;
          state_nxt = S_GHD;
        end else begin
          k_nxt    = k_r + NW'(1);
          addr_nxt = addr_r + IW'(1);
        end
      end
      S_GHD: begin
        we        = 1'b1;
        wdata     = {taken_h_r, IW'(n_r - NW'(1))};
        slot_nxt  = SLOT_W'(head_r);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_slot_nxt   = (status_r == ST_OK) ? slot_r : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      addr_r      <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r       <= head_nxt;
    kind_r       <= kind_nxt;
    n_r          <= n_nxt;
    lim_r        <= lim_nxt;
    s_r          <= s_nxt;
    d_r          <= d_nxt;
    k_r          <= k_nxt;
    old_r        <= old_nxt;
    taken_h_r    <= taken_h_nxt;
    rem_r        <= rem_nxt;
    hint_sh_r    <= hint_sh_nxt;
    cnt_r        <= cnt_nxt;
    status_r     <= status_nxt;
    slot_r       <= slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end
endmodule
